// ===== rtl/core/rmst_pkg.sv =====
// Shared types, constants and controller/datapath interface for the range max segment tree.
package rmst_pkg;

  localparam int unsigned MAX_LEAVES_DEF = 1024;
  localparam int unsigned LEAF_COUNT_W   = 11;
  localparam int unsigned INDEX_W        = 10;
  localparam int unsigned VALUE_W        = 31;
  localparam int unsigned MAX_W          = 32;

  localparam logic [LEAF_COUNT_W-1:0] LEAF_COUNT_RST = 11'd1024;
  localparam logic signed [MAX_W-1:0] NONE_VALUE     = '1;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [INDEX_W-1:0]   index;
    logic [INDEX_W-1:0]   right_index;
    logic [VALUE_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    logic signed [MAX_W-1:0] max_value;
    logic                    range_error;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic leaf_write;
    logic up_step;
    logic q_left;
    logic q_right;
    logic respond;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic err;
    logic op;
    logic pos_one;
    logic up_last;
    logic pos_lt_r;
    logic clear_last;
    logic slot_free;
  } dp_status_t;

endpackage

// ===== rtl/core/rmst_ctrl.sv =====
// Sequencing state machine for clear, update walk and range query walk.
module rmst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rmst_pkg::dp_status_t sts_i,
  output rmst_pkg::dp_cmd_t    cmd_o
);
  import rmst_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_DISPATCH = 8'b0000_0100,
    S_U_LEAF   = 8'b0000_1000,
    S_U_UP     = 8'b0001_0000,
    S_Q_LEFT   = 8'b0010_0000,
    S_Q_RIGHT  = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.err) begin
          state_d = S_RESP;
        end else if (sts_i.op == OP_UPDATE) begin
          state_d = S_U_LEAF;
        end else begin
          state_d = S_Q_LEFT;
        end
      end
      S_U_LEAF: begin
        cmd_o.leaf_write = 1'b1;
        state_d = sts_i.pos_one ? S_IDLE : S_U_UP;
      end
      S_U_UP: begin
        cmd_o.up_step = 1'b1;
        if (sts_i.up_last) state_d = S_IDLE;
      end
      S_Q_LEFT: begin
        // the exit pass through this state lets the last read fold into best_q before the response
        if (sts_i.pos_lt_r) begin
          cmd_o.q_left = 1'b1;
          state_d      = S_Q_RIGHT;
        end else begin
          state_d = S_RESP;
        end
      end
      S_Q_RIGHT: begin
        cmd_o.q_right = 1'b1;
        state_d       = S_Q_LEFT;
      end
      S_RESP: begin
        if (sts_i.slot_free) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_up_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_U_UP |-> !sts_i.pos_one)
    else $error("update walk above the root");

  a_resp_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESP |-> (sts_i.err || !sts_i.pos_lt_r))
    else $error("result sent before query walk finished");

  a_leaf_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.leaf_write |-> (!sts_i.err && (sts_i.op == OP_UPDATE)))
    else $error("leaf written for a bad or query item");

endmodule

// ===== rtl/core/rmst_datapath.sv =====
// Tree memory, walk position registers, max accumulation, config and output registers.
module rmst_datapath #(
  parameter int unsigned MaxLeaves = rmst_pkg::MAX_LEAVES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rmst_pkg::in_item_t                  in_item_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rmst_pkg::LEAF_COUNT_W-1:0]   cfg_data_i,
  input  rmst_pkg::dp_cmd_t                   cmd_i,
  output rmst_pkg::dp_status_t                sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rmst_pkg::out_item_t                 out_item_o
);
  import rmst_pkg::*;

  localparam int unsigned StoreDepth = 2 * MaxLeaves;
  localparam int unsigned AW = $clog2(StoreDepth);
  localparam int unsigned PW = AW + 1;   // holds 2*n, one past the last leaf
  localparam int unsigned CW = (PW > LEAF_COUNT_W) ? PW : LEAF_COUNT_W;

  logic [LEAF_COUNT_W-1:0] leaf_count_q;
  logic [CW-1:0]           lc_ext, live_n, lo_ext, hi_ext;
  logic                    lo_bad, hi_bad;

  logic               op_q, err_q;
  logic [VALUE_W-1:0] value_q, cur_q, best_q, rdata_q, up_max;
  logic               found_q, rd_pend_q;
  logic [PW-1:0]      pos_q, rpos_q, rpos_dec;
  logic [AW-1:0]      clr_cnt_q;
  logic               out_valid_q;
  out_item_t          out_item_q;

  logic               we, re, q_rd;
  logic [AW-1:0]      waddr, raddr;
  logic [VALUE_W-1:0] wdata;

  logic [VALUE_W-1:0] mem [StoreDepth];

  assign cfg_ready_o = 1'b1;

  always_comb begin
    lc_ext = CW'(leaf_count_q);
    if (lc_ext == '0) begin
      live_n = CW'(1);
    end else if (lc_ext > CW'(MaxLeaves)) begin
      live_n = CW'(MaxLeaves);
    end else begin
      live_n = lc_ext;
    end
    lo_ext = CW'(in_item_i.index);
    hi_ext = CW'(in_item_i.right_index);
    lo_bad = (lo_ext >= live_n);
    hi_bad = (hi_ext >= live_n);
  end

  assign up_max   = (cur_q > rdata_q) ? cur_q : rdata_q;
  assign rpos_dec = rpos_q - PW'(1);

  // one write and one read port; a sibling read rides along each update write
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    q_rd  = 1'b0;
    waddr = pos_q[AW-1:0];
    raddr = pos_q[AW-1:0];
    wdata = value_q;
    if (cmd_i.clear_step) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else if (cmd_i.leaf_write) begin
      we    = 1'b1;
      re    = 1'b1;
      raddr = {pos_q[AW-1:1], ~pos_q[0]};
    end else if (cmd_i.up_step) begin
      we    = 1'b1;
      waddr = pos_q[AW:1];
      wdata = up_max;
      re    = 1'b1;
      raddr = {pos_q[AW:2], ~pos_q[1]};
    end else if (cmd_i.q_left && pos_q[0]) begin
      re    = 1'b1;
      q_rd  = 1'b1;
    end else if (cmd_i.q_right && rpos_q[0]) begin
      re    = 1'b1;
      q_rd  = 1'b1;
      raddr = rpos_dec[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= LEAF_COUNT_RST;
      clr_cnt_q    <= '0;
      op_q         <= OP_UPDATE;
      err_q        <= 1'b0;
      found_q      <= 1'b0;
      rd_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) leaf_count_q <= cfg_data_i;
      if (cmd_i.clear_step) clr_cnt_q <= clr_cnt_q + AW'(1);
      if (cmd_i.load) begin
        op_q    <= in_item_i.op;
        err_q   <= (in_item_i.op == OP_QUERY) ? (lo_bad || hi_bad) : lo_bad;
        found_q <= 1'b0;
      end
      rd_pend_q <= q_rd;
      if (rd_pend_q) found_q <= 1'b1;
      if (cmd_i.respond) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= in_item_i.value;
      pos_q   <= PW'(lo_ext + live_n);
      rpos_q  <= PW'(hi_ext + live_n + CW'(1));
      best_q  <= '0;
    end
    if (cmd_i.leaf_write) cur_q <= value_q;
    if (cmd_i.up_step) begin
      cur_q <= up_max;
      pos_q <= {1'b0, pos_q[PW-1:1]};
    end
    if (cmd_i.q_left && pos_q[0]) pos_q <= pos_q + PW'(1);
    if (cmd_i.q_right) begin
      pos_q  <= {1'b0, pos_q[PW-1:1]};
      rpos_q <= {1'b0, rpos_q[PW-1:1]};
    end
    if (rd_pend_q && (!found_q || (rdata_q > best_q))) best_q <= rdata_q;
    if (cmd_i.respond) begin
      out_item_q.max_value   <= (err_q || !found_q) ? NONE_VALUE
                                                    : $signed({1'b0, best_q});
      out_item_q.range_error <= err_q;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.err        = err_q;
    sts_o.op         = op_q;
    sts_o.pos_one    = (pos_q == PW'(1));
    sts_o.up_last    = (pos_q[PW-1:1] == (PW-1)'(1));
    sts_o.pos_lt_r   = (pos_q < rpos_q);
    sts_o.clear_last = (clr_cnt_q == AW'(StoreDepth - 1));
    sts_o.slot_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_resp_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.respond |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites one not yet taken");

  a_up_halves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.up_step |=> pos_q == $past({1'b0, pos_q[PW-1:1]}))
    else $error("update walk position did not move to parent");

  a_qread_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.q_left && pos_q[0]) |-> (pos_q < PW'(StoreDepth)))
    else $error("query read beyond tree store");

endmodule

// ===== rtl/core/range_max_segment_tree.sv =====
// Range max segment tree top level: controller plus datapath with tree memory.
// Update: walks from the leaf up to the root one tree level per cycle, set by the single
//   memory write port; no result unless the index is out of range.
// Query: each tree level takes a left and a right step, as the single memory read port
//   serves one boundary read at a time. A bad index skips the walk to a range_error result.
// After reset a clearing pass zeroes the tree store with no item taken; configuration
//   writes are taken throughout.
module range_max_segment_tree #(
  parameter int unsigned MaxLeaves = rmst_pkg::MAX_LEAVES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rmst_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rmst_pkg::out_item_t               out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rmst_pkg::LEAF_COUNT_W-1:0] cfg_data_i
);
  import rmst_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  rmst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rmst_datapath #(
    .MaxLeaves (MaxLeaves)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
